[hdl/ptts_pkg.sv]
// Shared constants, codes and types of the priority tick task scheduler.
`default_nettype none
package ptts_pkg;

    // Width of the run, step and wait counters.
    localparam int COUNT_BITS = 8;
    // Width of the free-running tick time.
    localparam int TIME_BITS  = 16;

    // Fixed field widths of the ports.
    localparam int CFG_BITS   = 8;
    localparam int IDX_BITS   = 3;
    localparam int OUT_TIME_W = 16;
    localparam int NUM_W      = 8;

    // Configuration register indexes.
    localparam logic [IDX_BITS-1:0] REG_TASK0_RUNS     = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_TASK0_RUN_LEN  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_TASK0_WAIT_LEN = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_TASK1_RUNS     = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_TASK1_RUN_LEN  = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_TASK1_WAIT_LEN = 3'd5;

    // Configuration reset values.
    localparam logic [CFG_BITS-1:0] RST_TASK0_RUNS     = 8'd2;
    localparam logic [CFG_BITS-1:0] RST_TASK0_RUN_LEN  = 8'd8;
    localparam logic [CFG_BITS-1:0] RST_TASK0_WAIT_LEN = 8'd3;
    localparam logic [CFG_BITS-1:0] RST_TASK1_RUNS     = 8'd4;
    localparam logic [CFG_BITS-1:0] RST_TASK1_RUN_LEN  = 8'd2;
    localparam logic [CFG_BITS-1:0] RST_TASK1_WAIT_LEN = 8'd4;

    // Action reported for the served task.
    typedef enum logic [1:0] {
        ACT_RUN  = 2'd0,
        ACT_WAIT = 2'd1,
        ACT_STAY = 2'd2,
        ACT_DONE = 2'd3
    } act_t;

    // Per-task configuration.
    typedef struct packed {
        logic [CFG_BITS-1:0] runs;
        logic [CFG_BITS-1:0] run_len;
        logic [CFG_BITS-1:0] wait_len;
    } task_cfg_t;

    // Per-task status for the current tick.
    typedef struct packed {
        logic             runnable;
        logic             woke;
        act_t             act;
        logic [NUM_W-1:0] run_num;
        logic [NUM_W-1:0] step_num;
    } task_stat_t;

endpackage
`default_nettype wire

[hdl/ptts_task.sv]
// State and step logic of one scheduled task.
`default_nettype none
module ptts_task (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     step_en,
    input  wire                     serve,
    input  ptts_pkg::task_cfg_t     cfg,
    output ptts_pkg::task_stat_t    stat
);
    import ptts_pkg::*;

    typedef enum logic [1:0] {
        MODE_RUNNABLE = 2'd0,
        MODE_WAITING  = 2'd1,
        MODE_DONE     = 2'd2
    } mode_t;

    mode_t                 mode_reg, mode_next;
    logic [COUNT_BITS-1:0] run_index_reg, run_index_next;
    logic [COUNT_BITS-1:0] step_index_reg, step_index_next;
    logic [COUNT_BITS-1:0] wait_left_reg, wait_left_next;

    logic [COUNT_BITS-1:0] wait_dec;
    logic [COUNT_BITS-1:0] runs;
    logic [COUNT_BITS-1:0] run_len;
    logic [COUNT_BITS-1:0] wait_len;
    logic                  woke;
    act_t                  act;

    assign runs     = COUNT_BITS'(cfg.runs);
    assign run_len  = COUNT_BITS'(cfg.run_len);
    assign wait_len = COUNT_BITS'(cfg.wait_len);
    assign wait_dec = wait_left_reg - COUNT_BITS'(1);
    assign woke     = (mode_reg == MODE_WAITING) && (wait_dec == '0);

    // The step this task would take if it were served this tick.
    always_comb
    begin
        if (run_index_reg >= runs)
        begin
            act = ACT_DONE;
        end
        else if (step_index_reg < run_len)
        begin
            act = ACT_RUN;
        end
        else if (wait_len != '0)
        begin
            act = ACT_WAIT;
        end
        else
        begin
            act = ACT_STAY;
        end
    end

    always_comb
    begin
        stat.runnable = (mode_reg == MODE_RUNNABLE) || woke;
        stat.woke     = woke;
        stat.act      = act;
        stat.run_num  = NUM_W'(run_index_reg);
        stat.step_num = (act == ACT_RUN) ? NUM_W'(step_index_reg) : '0;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        run_index_next  = run_index_reg;
        step_index_next = step_index_reg;
        wait_left_next  = wait_left_reg;
        if (step_en)
        begin
            if (mode_reg == MODE_WAITING)
            begin
                wait_left_next = wait_dec;
                if (woke)
                begin
                    mode_next = MODE_RUNNABLE;
                end
            end
            if (serve)
            begin
                case (act)
                    ACT_DONE:
                    begin
                        mode_next = MODE_DONE;
                    end
                    ACT_RUN:
                    begin
                        step_index_next = step_index_reg + COUNT_BITS'(1);
                    end
                    ACT_WAIT:
                    begin
                        run_index_next  = run_index_reg + COUNT_BITS'(1);
                        step_index_next = '0;
                        wait_left_next  = wait_len;
                        mode_next       = MODE_WAITING;
                    end
                    ACT_STAY:
                    begin
                        run_index_next  = run_index_reg + COUNT_BITS'(1);
                        step_index_next = '0;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_RUNNABLE;
            run_index_reg  <= '0;
            step_index_reg <= '0;
            wait_left_reg  <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            run_index_reg  <= run_index_next;
            step_index_reg <= step_index_next;
            wait_left_reg  <= wait_left_next;
        end
    end

endmodule
`default_nettype wire

[hdl/priority_tick_task_scheduler.sv]
// Top level of the two-task fixed-priority tick scheduler.
`default_nettype none
//
//  Channel   Direction  Handshake                 Word contents
//  -------   ---------  ------------------------  ----------------------------------
//  input     in         in_valid / in_ready       tick
//  output    out        out_valid / out_ready     tick_time, served, task_res, action,
//                                                 run_number, step_number, woken_mask
//  config    in         cfg_wr_en (no handshake)  cfg_index, cfg_data
//
// Every input word is held in the input register and is then stepped into the
// result register, from which its result is offered on the output channel;
// one word is accepted per cycle when the output side keeps up.
// The step of both tasks is evaluated in parallel from the input register in a
// single pass.
// Reset clears the tick time, all task state and loads the default configuration.
// When a result is stalled an empty input register still takes one more word; after
// that in_ready drops until the result is taken.
module priority_tick_task_scheduler (
    input  wire                              clk,
    input  wire                              rst_n,

    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              tick,

    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [ptts_pkg::OUT_TIME_W-1:0]  tick_time,
    output logic                             served,
    output logic                             task_res,
    output logic [1:0]                       action,
    output logic [ptts_pkg::NUM_W-1:0]       run_number,
    output logic [ptts_pkg::NUM_W-1:0]       step_number,
    output logic [1:0]                       woken_mask,

    input  wire                              cfg_wr_en,
    input  wire  [ptts_pkg::IDX_BITS-1:0]    cfg_index,
    input  wire  [ptts_pkg::CFG_BITS-1:0]    cfg_data
);
    import ptts_pkg::*;

    // Configuration registers, one set per task.
    task_cfg_t cfg0_reg;
    task_cfg_t cfg1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg0_reg.runs     <= RST_TASK0_RUNS;
            cfg0_reg.run_len  <= RST_TASK0_RUN_LEN;
            cfg0_reg.wait_len <= RST_TASK0_WAIT_LEN;
            cfg1_reg.runs     <= RST_TASK1_RUNS;
            cfg1_reg.run_len  <= RST_TASK1_RUN_LEN;
            cfg1_reg.wait_len <= RST_TASK1_WAIT_LEN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TASK0_RUNS:     cfg0_reg.runs     <= cfg_data;
                REG_TASK0_RUN_LEN:  cfg0_reg.run_len  <= cfg_data;
                REG_TASK0_WAIT_LEN: cfg0_reg.wait_len <= cfg_data;
                REG_TASK1_RUNS:     cfg1_reg.runs     <= cfg_data;
                REG_TASK1_RUN_LEN:  cfg1_reg.run_len  <= cfg_data;
                REG_TASK1_WAIT_LEN: cfg1_reg.wait_len <= cfg_data;
                default:            cfg0_reg          <= cfg0_reg;
            endcase
        end
    end

    // Pipeline control. The input register moves into the result register
    // whenever the result register is empty or being drained this cycle.
    logic s1_valid_reg;
    logic s1_tick_reg;
    logic out_valid_reg;
    logic advance;
    logic process;
    logic step_en;

    assign advance  = !out_valid_reg || out_ready;
    assign process  = s1_valid_reg && advance;
    assign in_ready = !s1_valid_reg || advance;
    assign step_en  = process && s1_tick_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_tick_reg <= tick;
        end
    end

    // Tick time advances once per real tick; idle words leave it alone.
    logic [TIME_BITS-1:0] time_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg <= '0;
        end
        else if (step_en)
        begin
            time_reg <= time_reg + TIME_BITS'(1);
        end
    end

    // Both tasks evaluate their wake and step in parallel; task 0 wins.
    task_stat_t stat0;
    task_stat_t stat1;
    logic       serve0;
    logic       serve1;

    assign serve0 = stat0.runnable;
    assign serve1 = !stat0.runnable && stat1.runnable;

    ptts_task u_task0 (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .serve   (serve0),
        .cfg     (cfg0_reg),
        .stat    (stat0)
    );

    ptts_task u_task1 (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .serve   (serve1),
        .cfg     (cfg1_reg),
        .stat    (stat1)
    );

    // Result word assembly. An idle word reports the time and zeros elsewhere.
    logic             served_c;
    logic             task_c;
    logic [1:0]       action_c;
    logic [NUM_W-1:0] run_c;
    logic [NUM_W-1:0] step_c;
    logic [1:0]       woken_c;

    always_comb
    begin
        served_c = 1'b0;
        task_c   = 1'b0;
        action_c = ACT_RUN;
        run_c    = '0;
        step_c   = '0;
        woken_c  = '0;
        if (s1_tick_reg)
        begin
            woken_c = {stat1.woke, stat0.woke};
            if (serve0)
            begin
                served_c = 1'b1;
                action_c = stat0.act;
                run_c    = stat0.run_num;
                step_c   = stat0.step_num;
            end
            else if (serve1)
            begin
                served_c = 1'b1;
                task_c   = 1'b1;
                action_c = stat1.act;
                run_c    = stat1.run_num;
                step_c   = stat1.step_num;
            end
        end
    end

    logic [OUT_TIME_W-1:0] tick_time_reg;
    logic                  served_reg;
    logic                  task_res_reg;
    logic [1:0]            action_reg;
    logic [NUM_W-1:0]      run_number_reg;
    logic [NUM_W-1:0]      step_number_reg;
    logic [1:0]            woken_mask_reg;

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            tick_time_reg   <= OUT_TIME_W'(time_reg);
            served_reg      <= served_c;
            task_res_reg    <= task_c;
            action_reg      <= action_c;
            run_number_reg  <= run_c;
            step_number_reg <= step_c;
            woken_mask_reg  <= woken_c;
        end
    end

    assign out_valid   = out_valid_reg;
    assign tick_time   = tick_time_reg;
    assign served      = served_reg;
    assign task_res    = task_res_reg;
    assign action      = action_reg;
    assign run_number  = run_number_reg;
    assign step_number = step_number_reg;
    assign woken_mask  = woken_mask_reg;

endmodule
`default_nettype wire

[tb/sv/tb_priority_tick_task_scheduler.sv]
// Self-checking testbench for the two-task fixed-priority tick scheduler.
module tb_priority_tick_task_scheduler;
    import ptts_pkg::*;

    // The run is stopped by the watchdog if it has not ended by this cycle.
    localparam int CYCLE_LIMIT = 1000000;
    // Shape of the random part: phases of one setting each, words per phase.
    localparam int RAND_PHASES = 22;
    localparam int PHASE_WORDS = 62;
    localparam int DIR_ROWS    = 16;
    // Words sent back to back with no idling on either side.
    localparam int CALM_WORDS  = 160;
    // Words sent once both tasks have been told to finish.
    localparam int CLOSE_WORDS = 12;
    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [IDX_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

    // Life cycle of one task as the predictor tracks it.
    typedef enum logic [1:0] {
        TS_READY   = 2'd0,
        TS_WAITING = 2'd1,
        TS_DONE    = 2'd2
    } task_state_t;

    // One result word, field for field as the ports carry it.
    typedef struct packed {
        logic [OUT_TIME_W-1:0] tm;
        logic                  srv;
        logic                  who;
        act_t                  act;
        logic [NUM_W-1:0]      rn;
        logic [NUM_W-1:0]      sn;
        logic [1:0]            woke;
    } sched_res_t;

    // One row of the directed table. When load is set, the block is drained
    // and both task settings are written before the row's word goes out.
    // When typed is set, res holds the result written out by hand; otherwise
    // the predictor supplies it.
    typedef struct packed {
        logic       load;
        task_cfg_t  c0;
        task_cfg_t  c1;
        logic       tick;
        logic       typed;
        sched_res_t res;
    } dir_row_t;

    localparam task_cfg_t CFG_UNUSED  = '0;
    // Zero wait, so each run phase ends in a yield that stays runnable; task 0's run length is zero.
    localparam task_cfg_t CFG_STAY0   = '{8'd255, 8'd0, 8'd0};
    localparam task_cfg_t CFG_STAY1   = '{8'd255, 8'd1, 8'd0};
    // Task 0 waits two ticks and task 1 one tick, one tick later, so both
    // counts run out on the same tick.
    localparam task_cfg_t CFG_WAKE0   = '{8'd255, 8'd0, 8'd2};
    localparam task_cfg_t CFG_WAKE1   = '{8'd255, 8'd0, 8'd1};
    // Longest wait for task 0 while task 1 keeps running.
    localparam task_cfg_t CFG_LONG0   = '{8'd255, 8'd0, 8'd255};
    localparam task_cfg_t CFG_LONG1   = '{8'd255, 8'd4, 8'd1};
    // Every counter at its top value.
    localparam task_cfg_t CFG_LONGEST = '{8'd255, 8'd255, 8'd255};

    localparam sched_res_t RES_PREDICT = '0;
    // An idle word reports the time and nothing else.
    localparam sched_res_t RES_IDLE_AT0 = '{16'd0, 1'b0, 1'b0, ACT_RUN, 8'd0, 8'd0, 2'd0};
    // The first tick after reset is task 0's first run step.
    localparam sched_res_t RES_FIRST    = '{16'd0, 1'b1, 1'b0, ACT_RUN, 8'd0, 8'd0, 2'd0};

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  tick;
    logic                  out_valid;
    logic                  out_ready;
    logic [OUT_TIME_W-1:0] tick_time;
    logic                  served;
    logic                  task_res;
    logic [1:0]            action;
    logic [NUM_W-1:0]      run_number;
    logic [NUM_W-1:0]      step_number;
    logic [1:0]            woken_mask;
    logic                  cfg_wr_en;
    logic [IDX_BITS-1:0]   cfg_index;
    logic [CFG_BITS-1:0]   cfg_data;

    // Predictor copy of the scheduler: time, per-task state and settings.
    logic [OUT_TIME_W-1:0] p_time;
    task_state_t           p_mode [2];
    logic [NUM_W-1:0]      p_run  [2];
    logic [NUM_W-1:0]      p_step [2];
    logic [NUM_W-1:0]      p_wait [2];
    task_cfg_t             p_cfg  [2];

    // Results owed by the block, oldest first.
    sched_res_t            due_results [$];
    dir_row_t              dir_tab [DIR_ROWS];
    int                    mismatch_count;
    int                    cycle_count;
    // While calm is set neither side idles.
    bit                    calm;

    priority_tick_task_scheduler dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .tick        (tick),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tick_time   (tick_time),
        .served      (served),
        .task_res    (task_res),
        .action      (action),
        .run_number  (run_number),
        .step_number (step_number),
        .woken_mask  (woken_mask),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The watchdog counts cycles and ends a run that hangs.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic cmp_field(input string what, input logic [15:0] got,
                             input logic [15:0] want, input logic [15:0] at_time);
        if (got !== want)
            flag_mismatch($sformatf("tick %0d %s got %0h want %0h", at_time, what, got, want));
    endtask

    // Advances the predictor by one input word and returns the result that the
    // word must produce. Waits are counted down first, then the first runnable
    // task in priority order takes one step against the live settings.
    function automatic sched_res_t step_scheduler(input logic t);
        sched_res_t r;
        int         k;
        bit         picked;
        r = '0;
        r.tm = p_time;
        if (!t)
            return r;
        for (k = 0; k < 2; k++)
        begin
            if (p_mode[k] == TS_WAITING)
            begin
                p_wait[k] = p_wait[k] - 8'd1;
                if (p_wait[k] == 8'd0)
                begin
                    p_mode[k] = TS_READY;
                    r.woke[k] = 1'b1;
                end
            end
        end
        picked = 1'b0;
        for (k = 0; k < 2; k++)
        begin
            if (!picked && p_mode[k] == TS_READY)
            begin
                picked = 1'b1;
                r.srv  = 1'b1;
                r.who  = (k == 1);
                r.rn   = p_run[k];
                if (p_run[k] >= p_cfg[k].runs)
                begin
                    // All run phases done, or the run count was lowered below them.
                    r.act     = ACT_DONE;
                    p_mode[k] = TS_DONE;
                end
                else if (p_step[k] < p_cfg[k].run_len)
                begin
                    r.act     = ACT_RUN;
                    r.sn      = p_step[k];
                    p_step[k] = p_step[k] + 8'd1;
                end
                else
                begin
                    // End of a run phase: yield, into a wait unless its length is zero.
                    p_run[k]  = p_run[k] + 8'd1;
                    p_step[k] = 8'd0;
                    if (p_cfg[k].wait_len != 8'd0)
                    begin
                        r.act     = ACT_WAIT;
                        p_wait[k] = p_cfg[k].wait_len;
                        p_mode[k] = TS_WAITING;
                    end
                    else
                    begin
                        r.act = ACT_STAY;
                    end
                end
            end
        end
        p_time = p_time + 16'd1;
        return r;
    endfunction

    // Random setting for one task. The run count mostly stays well above the
    // phases already done so that the tasks live through the random part.
    function automatic task_cfg_t rand_cfg(input logic [NUM_W-1:0] run_now);
        task_cfg_t c;
        int        lo;
        int        pick;
        lo = int'(run_now) + 40;
        if (lo > 255)
            lo = 255;
        c.runs = ($urandom_range(0, 99) < 70) ? 8'd255 : 8'($urandom_range(255, lo));
        pick = $urandom_range(0, 99);
        if (pick < 10)
            c.run_len = 8'd0;
        else if (pick < 15)
            c.run_len = 8'd255;
        else
            c.run_len = 8'($urandom_range(1, 24));
        pick = $urandom_range(0, 99);
        if (pick < 15)
            c.wait_len = 8'd0;
        else if (pick < 20)
            c.wait_len = 8'd255;
        else
            c.wait_len = 8'($urandom_range(1, 12));
        return c;
    endfunction

    // Sends one word: random idle cycles first unless calm, then valid is held until the
    // handshake. The expectation is worked out at the edge of acceptance.
    task automatic push_word(input logic t, input logic typed, input sched_res_t typed_res);
        sched_res_t r;
        while (!calm && $urandom_range(0, 99) < 33)
        begin
            in_valid <= 1'b0;
            tick     <= 1'($urandom_range(0, 1));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        tick     <= t;
        do
            @(posedge clk);
        while (!in_ready);
        r = step_scheduler(t);
        due_results.push_back(typed ? typed_res : r);
    endtask

    // Stops sending and waits until every owed result has been taken, so the
    // block is idle and the settings may be changed.
    task automatic settle();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    // Writes all registers back to back, plus the two unmapped indexes with
    // random data, and then updates the predictor's copy of the settings.
    task automatic load_regs(input task_cfg_t c0, input task_cfg_t c1);
        logic [IDX_BITS-1:0] regs [8];
        logic [CFG_BITS-1:0] vals [8];
        int                  i;
        regs[0] = REG_TASK0_RUNS;     vals[0] = c0.runs;
        regs[1] = REG_TASK0_RUN_LEN;  vals[1] = c0.run_len;
        regs[2] = REG_TASK0_WAIT_LEN; vals[2] = c0.wait_len;
        regs[3] = REG_TASK1_RUNS;     vals[3] = c1.runs;
        regs[4] = REG_TASK1_RUN_LEN;  vals[4] = c1.run_len;
        regs[5] = REG_TASK1_WAIT_LEN; vals[5] = c1.wait_len;
        regs[6] = REG_UNMAPPED_LO;    vals[6] = 8'($urandom_range(0, 255));
        regs[7] = REG_UNMAPPED_HI;    vals[7] = 8'($urandom_range(0, 255));
        for (i = 0; i < 8; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        p_cfg[0] = c0;
        p_cfg[1] = c1;
    endtask

    // The receiver stalls about a third of the cycles, except while calm.
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(0, 99) >= 33);
    end

    // Every result word taken is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        sched_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                flag_mismatch($sformatf("result word at tick %0d with none owed", tick_time));
            end
            else
            begin
                want = due_results.pop_front();
                cmp_field("tick_time", tick_time, want.tm, want.tm);
                cmp_field("served", served, want.srv, want.tm);
                cmp_field("task_res", task_res, want.who, want.tm);
                cmp_field("action", action, want.act, want.tm);
                cmp_field("run_number", run_number, want.rn, want.tm);
                cmp_field("step_number", step_number, want.sn, want.tm);
                cmp_field("woken_mask", woken_mask, want.woke, want.tm);
            end
        end
    end

    initial
    begin : stimulus
        int        i;
        int        k;
        int        n;
        task_cfg_t c0;
        task_cfg_t c1;

        in_valid  <= 1'b0;
        tick      <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        mismatch_count = 0;
        calm = 1'b0;

        // Predictor starts from the reset state of the block.
        p_time = '0;
        for (k = 0; k < 2; k++)
        begin
            p_mode[k] = TS_READY;
            p_run[k]  = '0;
            p_step[k] = '0;
            p_wait[k] = '0;
        end
        p_cfg[0] = '{RST_TASK0_RUNS, RST_TASK0_RUN_LEN, RST_TASK0_WAIT_LEN};
        p_cfg[1] = '{RST_TASK1_RUNS, RST_TASK1_RUN_LEN, RST_TASK1_WAIT_LEN};

        // Directed part. It starts on the reset settings, then walks through
        // yields that stay runnable, both tasks waking on one tick, the longest wait
        // and idle words.
        dir_tab = '{
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b0, 1'b1, RES_IDLE_AT0},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b1, RES_FIRST},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b1, CFG_STAY0,  CFG_STAY1,  1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b1, CFG_WAKE0,  CFG_WAKE1,  1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b1, CFG_LONG0,  CFG_LONG1,  1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b0, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b1, 1'b0, RES_PREDICT},
            '{1'b0, CFG_UNUSED, CFG_UNUSED, 1'b0, 1'b0, RES_PREDICT}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_tab[i].load)
            begin
                settle();
                load_regs(dir_tab[i].c0, dir_tab[i].c1);
            end
            push_word(dir_tab[i].tick, dir_tab[i].typed, dir_tab[i].res);
        end

        // Random part: a new pair of settings per phase, mostly ticks with a
        // few idle words mixed in.
        for (k = 0; k < RAND_PHASES; k++)
        begin
            settle();
            load_regs(rand_cfg(p_run[0]), rand_cfg(p_run[1]));
            for (n = 0; n < PHASE_WORDS; n++)
                push_word(($urandom_range(0, 99) < 8) ? 1'b0 : 1'b1, 1'b0, RES_PREDICT);
        end

        // A long stretch with no idling on either side, with every counter
        // at its top value, so words follow each other on every cycle.
        settle();
        calm = 1'b1;
        load_regs(CFG_LONGEST, CFG_LONGEST);
        for (i = 0; i < CALM_WORDS; i++)
            push_word(1'b1, 1'b0, RES_PREDICT);
        settle();
        calm = 1'b0;

        // A run count of zero finishes a task on its next step; after that
        // neither task is ever served again.
        c0 = rand_cfg(p_run[0]);
        c1 = rand_cfg(p_run[1]);
        c0.runs = 8'd0;
        c1.runs = 8'd0;
        load_regs(c0, c1);
        for (i = 0; i < CLOSE_WORDS; i++)
            push_word((i < 3) ? 1'b1 : 1'($urandom_range(0, 1)), 1'b0, RES_PREDICT);
        settle();

        // Give a stray extra result time to show up before the verdict.
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
